FILE: hw/rtl/adcrq_pkg.sv
// Shared types and constants for the ADC sample ring queue.
package adcrq_pkg;

  // Empty marker held by a free slot
  localparam logic [7:0] EMPTY_MARK = 8'hFF;

  // Default sizes
  localparam int unsigned DEF_QUEUE_DEPTH  = 48;
  localparam int unsigned DEF_MUX_CHANNELS = 8;

  // Fixed result field widths
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned CHAN_OUT_W = 3;
  localparam int unsigned AVAIL_OUT_W = 6;

  // Item codes
  localparam logic OP_CONV = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

FILE: hw/rtl/adcrq_slot_ram.sv
// Slot memory: one write port, one registered read port, per-slot valid bits.
module adcrq_slot_ram #(
  parameter int unsigned QUEUE_DEPTH = adcrq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned PTR_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [PTR_W-1:0]              rd_addr_i,
  output logic [adcrq_pkg::SAMPLE_W-1:0] rd_data_o,
  input  logic                          wr_en_i,
  input  logic [PTR_W-1:0]              wr_addr_i,
  input  logic [adcrq_pkg::SAMPLE_W-1:0] wr_data_i
);
  import adcrq_pkg::*;

  logic [SAMPLE_W-1:0]    mem [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_q;
  logic [SAMPLE_W-1:0]    rd_mem_q;
  logic                   rd_vld_q;

  // Data array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_mem_q <= mem[rd_addr_i];
    end
  end

  // Written flags; an unwritten slot reads as the empty marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_mem_q : EMPTY_MARK;

endmodule

FILE: hw/rtl/adc_sample_ring_queue_top.sv
// Top level of the ADC sample ring queue: sequencer, pointers and result registers.
//
//   channel  | direction | handshake          | fields
//   command  | in        | start, busy        | opcode_i, conversion_value_i
//   result   | out       | done_o (one cycle) | popped_sample_o, sample_kept_o,
//            |           |                    | push_accepted_o, mux_channel_o,
//            |           |                    | available_count_o
//
// An item is handled as a read and then a write-back: the slot is read at the accept
// edge, then modified and written back in ST_EXEC; the write-back waits on the
// registered read port of the slot memory.
// done_o pulses in the cycle after busy, while the next item may already start.
// Reset marks every slot empty at once through its valid bit; no clearing pass.
// The receiver cannot stall; busy is high for one cycle after each accept.
module adc_sample_ring_queue_top #(
  parameter int unsigned QUEUE_DEPTH  = adcrq_pkg::DEF_QUEUE_DEPTH,
  parameter int unsigned MUX_CHANNELS = adcrq_pkg::DEF_MUX_CHANNELS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode_i,
  input  logic [adcrq_pkg::SAMPLE_W-1:0]    conversion_value_i,
  output logic                              done_o,
  output logic [adcrq_pkg::SAMPLE_W-1:0]    popped_sample_o,
  output logic                              sample_kept_o,
  output logic                              push_accepted_o,
  output logic [adcrq_pkg::CHAN_OUT_W-1:0]  mux_channel_o,
  output logic [adcrq_pkg::AVAIL_OUT_W-1:0] available_count_o
);
  import adcrq_pkg::*;

  localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = PTR_W + 1;
  localparam int unsigned CHAN_W = $clog2(MUX_CHANNELS);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CHAN_W-1:0] CHAN_LAST = CHAN_W'(MUX_CHANNELS - 1);

  state_e state_q, state_d;

  logic [PTR_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic                take_q, take_d;
  logic [CHAN_W-1:0]   chan_q, chan_d;
  logic                op_q;
  logic [SAMPLE_W-1:0] value_q;

  logic                accept;
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  logic [SAMPLE_W-1:0] slot;
  logic                wr_en;
  logic [PTR_W-1:0]    wr_addr;
  logic [SAMPLE_W-1:0] wr_data;

  logic [SAMPLE_W-1:0] popped_d;
  logic                kept_d, acc_d;
  logic [CNT_W-1:0]    avail_d;

  logic                done_q;
  logic [SAMPLE_W-1:0] popped_q;
  logic                kept_q, acc_q;
  logic [CHAN_W-1:0]   chan_out_q;
  logic [CNT_W-1:0]    avail_q;

  // Slot memory
  adcrq_slot_ram #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PTR_W       (PTR_W)
  ) u_slots (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (slot),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy  = 1'b0;
    rd_en = 1'b0;
    unique case (state_q)
      ST_IDLE: rd_en = start;
      ST_EXEC: busy  = 1'b1;
      default: busy  = 1'b0;
    endcase
  end

  assign accept  = start && !busy;
  assign rd_addr = (opcode_i == OP_POP) ? tail_q : head_q;

  // Read-modify-write of the addressed slot
  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    take_d   = take_q;
    chan_d   = chan_q;
    popped_d = EMPTY_MARK;
    kept_d   = 1'b0;
    acc_d    = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = head_q;
    wr_data  = value_q;
    if (state_q == ST_EXEC) begin
      if (op_q == OP_CONV) begin
        if (take_q) begin
          kept_d = 1'b1;
          if (slot == EMPTY_MARK) begin
            wr_en  = 1'b1;
            acc_d  = 1'b1;
            head_d = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
          end
          chan_d = (chan_q == CHAN_LAST) ? '0 : chan_q + 1'b1;
          take_d = 1'b0;
        end else begin
          take_d = 1'b1;
        end
      end else if (slot != EMPTY_MARK) begin
        popped_d = slot;
        wr_en    = 1'b1;
        wr_addr  = tail_q;
        wr_data  = EMPTY_MARK;
        tail_d   = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
      end
    end
  end

  // Fill level after this item, modulo depth
  always_comb begin
    if (head_d >= tail_d) begin
      avail_d = CNT_W'(head_d) - CNT_W'(tail_d);
    end else begin
      avail_d = DEPTH_CNT - (CNT_W'(tail_d) - CNT_W'(head_d));
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      take_q  <= 1'b1;
      chan_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      take_q  <= take_d;
      chan_q  <= chan_d;
      done_q  <= (state_q == ST_EXEC);
    end
  end

  // Item capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      value_q <= conversion_value_i;
    end
    if (state_q == ST_EXEC) begin
      popped_q   <= popped_d;
      kept_q     <= kept_d;
      acc_q      <= acc_d;
      chan_out_q <= chan_d;
      avail_q    <= avail_d;
    end
  end

  assign done_o            = done_q;
  assign popped_sample_o   = popped_q;
  assign sample_kept_o     = kept_q;
  assign push_accepted_o   = acc_q;
  assign mux_channel_o     = CHAN_OUT_W'(chan_out_q);
  assign available_count_o = AVAIL_OUT_W'(avail_q);

  // Checks
  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy) else $error("busy held longer than one cycle");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o) else $error("no result after an item");

  a_acc_needs_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && push_accepted_o |-> sample_kept_o && popped_sample_o == EMPTY_MARK)
    else $error("stored push without a kept conversion");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= PTR_LAST && tail_q <= PTR_LAST) else $error("pointer out of range");

  a_pop_moves_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC && op_q == OP_POP && slot != EMPTY_MARK |=> tail_q != $past(tail_q))
    else $error("tail did not advance on a pop");

endmodule

FILE: sim/adc_sample_ring_queue_top_test.sv
// Testbench for the ADC sample ring queue: item driver, ring predictor and result checker.
module adc_sample_ring_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import adcrq_pkg::*;

  localparam int unsigned DEPTH    = DEF_QUEUE_DEPTH;
  localparam int unsigned CHANNELS = DEF_MUX_CHANNELS;
  localparam int unsigned RANDOM_ITEMS = 650;

  // One result as the block reports it
  typedef struct packed {
    logic [SAMPLE_W-1:0]    popped;
    logic                   kept;
    logic                   stored;
    logic [CHAN_OUT_W-1:0]  chan;
    logic [AVAIL_OUT_W-1:0] avail;
  } ring_result_t;

  // Ring queue predictor plus the queue of results still owed by the block
  class adc_ring_scoreboard;
    logic [SAMPLE_W-1:0] slots [DEPTH];
    int unsigned         head;
    int unsigned         tail;
    bit                  keep_next;
    int unsigned         chan;
    ring_result_t        owed [$];
    int unsigned         failures;

    function new();
      for (int i = 0; i < DEPTH; i++) slots[i] = EMPTY_MARK;
      head      = 0;
      tail      = 0;
      keep_next = 1'b1;
      chan      = 0;
      failures  = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // Apply one accepted item to the ring and queue the result it causes
    function void note_item(logic op, logic [SAMPLE_W-1:0] val);
      ring_result_t r;
      int unsigned  fill;
      r.popped = EMPTY_MARK;
      r.kept   = 1'b0;
      r.stored = 1'b0;
      if (op == OP_CONV) begin
        if (keep_next) begin
          r.kept = 1'b1;
          // drop the sample when the head slot still holds data
          if (slots[head] == EMPTY_MARK) begin
            slots[head] = val;
            head        = (head + 1 >= DEPTH) ? 0 : head + 1;
            r.stored    = 1'b1;
          end
          chan      = (chan + 1 >= CHANNELS) ? 0 : chan + 1;
          keep_next = 1'b0;
        end else begin
          keep_next = 1'b1;
        end
      end else if (slots[tail] != EMPTY_MARK) begin
        r.popped    = slots[tail];
        slots[tail] = EMPTY_MARK;
        tail        = (tail + 1 >= DEPTH) ? 0 : tail + 1;
      end
      fill    = (head >= tail) ? head - tail : DEPTH - (tail - head);
      r.chan  = chan[CHAN_OUT_W-1:0];
      r.avail = fill[AVAIL_OUT_W-1:0];
      owed.push_back(r);
    endfunction

    // Compare one result with the oldest one owed
    function void check_result(ring_result_t got);
      ring_result_t exp_r;
      if (owed.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result with nothing owed: %p", $realtime, got);
        return;
      end
      exp_r = owed.pop_front();
      if (got !== exp_r) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result mismatch: expected %p, got %p", $realtime, exp_r, got);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic                   opcode_i;
  logic [SAMPLE_W-1:0]    conversion_value_i;
  logic                   done_o;
  logic [SAMPLE_W-1:0]    popped_sample_o;
  logic                   sample_kept_o;
  logic                   push_accepted_o;
  logic [CHAN_OUT_W-1:0]  mux_channel_o;
  logic [AVAIL_OUT_W-1:0] available_count_o;

  adc_ring_scoreboard ring_sb;

  adc_sample_ring_queue_top DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .conversion_value_i(conversion_value_i),
    .done_o            (done_o),
    .popped_sample_o   (popped_sample_o),
    .sample_kept_o     (sample_kept_o),
    .push_accepted_o   (push_accepted_o),
    .mux_channel_o     (mux_channel_o),
    .available_count_o (available_count_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch both handshakes at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && ring_sb != null) begin
      if (start && !busy) ring_sb.note_item(opcode_i, conversion_value_i);
      if (done_o)
        ring_sb.check_result({popped_sample_o, sample_kept_o, push_accepted_o,
                              mux_channel_o, available_count_o});
    end
  end

  // Present one item and hold it until the block takes it
  task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] val);
    @(negedge clk_i);
    start              <= 1'b1;
    opcode_i           <= op;
    conversion_value_i <= val;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
  endtask

  task automatic hold_off(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Stop sending until every owed result has come back
  task automatic drain_ring();
    hold_off(1);
    while (ring_sb.pending() != 0) @(posedge clk_i);
  endtask

  // Mostly random samples, a few on the empty marker and on zero
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return EMPTY_MARK;
    if (r < 5) return '0;
    return SAMPLE_W'($urandom_range(0, 255));
  endfunction

  // Overall time limit
  initial begin
    #500us;
    $display("adc_sample_ring_queue_top_test failed");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned burst_len;
    int unsigned burst_kind;
    int unsigned pop_pct;
    int unsigned waited;
    bit          quiet;
    logic        op;

    rst_ni             = 1'b0;
    start              = 1'b0;
    opcode_i           = OP_CONV;
    conversion_value_i = '0;
    ring_sb            = new();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty pop, alternate decimation, stored empty marker, stuck tail
    send_item(OP_POP,  8'h00);
    send_item(OP_CONV, 8'h00);
    send_item(OP_CONV, 8'hAA);
    send_item(OP_CONV, EMPTY_MARK);
    send_item(OP_CONV, 8'h55);
    send_item(OP_CONV, 8'h80);
    send_item(OP_CONV, 8'h7F);
    send_item(OP_POP,  8'hFF);
    send_item(OP_POP,  8'h00);
    send_item(OP_POP,  8'h00);
    send_item(OP_CONV, 8'h01);
    send_item(OP_CONV, 8'hFE);
    send_item(OP_CONV, 8'hFF);
    send_item(OP_POP,  8'h12);
    hold_off(2);
    send_item(OP_CONV, 8'hC3);
    send_item(OP_POP,  8'h00);
    send_item(OP_CONV, 8'h3C);
    send_item(OP_CONV, 8'h00);
    send_item(OP_POP,  8'h00);
    send_item(OP_POP,  8'h00);
    drain_ring();

    // Random bursts: fill runs to reach a full ring and dropped samples,
    // drain runs to empty it, mixed traffic in between
    sent = 0;
    burst_kind = 1;
    burst_len = 120;
    while (sent < RANDOM_ITEMS) begin
      case (burst_kind)
        0: pop_pct = 50;
        1: pop_pct = 4;
        default: pop_pct = 90;
      endcase
      repeat (burst_len) begin
        if (sent >= RANDOM_ITEMS) break;
        quiet = (sent >= 250 && sent < 420);
        if (!quiet && $urandom_range(0, 99) < 8) hold_off($urandom_range(1, 4));
        op = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_CONV;
        send_item(op, pick_sample());
        sent++;
      end
      // pause once mid-run until the ring has answered everything
      if (sent >= 300 && sent < 300 + burst_len) drain_ring();
      burst_kind = $urandom_range(0, 2);
      burst_len  = $urandom_range(10, 100);
    end

    // Wait for the last results, with a bound
    hold_off(1);
    waited = 0;
    while (ring_sb.pending() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (5) @(posedge clk_i);

    if (ring_sb.failures == 0 && ring_sb.pending() == 0) begin
      $display("adc_sample_ring_queue_top_test passed");
    end else begin
      $display("adc_sample_ring_queue_top_test failed");
    end
    $finish;
  end

endmodule
